### rtl/core/tmman_pkg.sv
package tmman_pkg;

    localparam int CH_W        = 3;
    localparam int SAMPLE_W    = 12;
    localparam int FS_W        = 14;
    localparam int LEVEL_W     = 10;
    localparam int PROD_W      = FS_W + LEVEL_W;
    localparam int NUM_SAMPLES = 6;
    localparam int HIST_DEPTH  = 3;
    localparam int FS_REGS     = 8;
    localparam int FS_IDX_W    = 3;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    localparam int CHANNELS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [LEVEL_W-1:0] LEVEL_SCALE = 10'd1000;

    typedef logic [FS_W-1:0] fs_array_t [FS_REGS];

    localparam fs_array_t FS_RESET = '{
        14'd1590, 14'd1542, 14'd1680, 14'd1540,
        14'd1590, 14'd5030, 14'd5026, 14'd5690
    };

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [FS_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quotient;
    } div_rsp_t;

endpackage

### rtl/core/tmman_if.sv
interface tmman_in_if import tmman_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
    logic [SAMPLE_W-1:0] sample_d;
    logic [SAMPLE_W-1:0] sample_e;
    logic [SAMPLE_W-1:0] sample_f;

    modport source (
        output valid, channel, sample_a, sample_b, sample_c, sample_d, sample_e, sample_f,
        input  ready
    );
    modport sink (
        input  valid, channel, sample_a, sample_b, sample_c, sample_d, sample_e, sample_f,
        output ready
    );
endinterface

interface tmman_out_if import tmman_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    out_channel;
    logic [LEVEL_W-1:0] level;

    modport source (
        output valid, out_channel, level,
        input  ready
    );
    modport sink (
        input  valid, out_channel, level,
        output ready
    );
endinterface

### rtl/core/tmman_ram.sv
module tmman_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/tmman_regs.sv
module tmman_regs import tmman_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output fs_array_t             full_scale
);

    fs_array_t           fs_reg;
    logic [FS_IDX_W-1:0] idx;

    assign idx    = paddr[FS_IDX_W+1:2];
    assign pready = 1'b1;
    assign prdata = APB_DATA_W'(fs_reg[idx]);
    assign full_scale = fs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= FS_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            fs_reg[idx] <= pwdata[FS_W-1:0];
        end
    end

endmodule

### rtl/core/tmman_div.sv
module tmman_div import tmman_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(LEVEL_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [FS_W-1:0]     rem_reg;
    logic [FS_W-1:0]     dvs_reg;
    logic [LEVEL_W-1:0]  dvd_reg;
    logic [LEVEL_W-1:0]  quot_reg;

    logic [FS_W:0]       trial;
    logic                fits;
    logic [FS_W:0]       diff;

    // The quotient is known to be below 2^LEVEL_W, so the upper dividend bits
    // already form a partial remainder smaller than the divisor.
    assign trial = {rem_reg, dvd_reg[LEVEL_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(LEVEL_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.dividend[PROD_W-1:LEVEL_W];
            dvd_reg  <= req.dividend[LEVEL_W-1:0];
            dvs_reg  <= req.divisor;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[FS_W-1:0] : trial[FS_W-1:0];
            dvd_reg  <= {dvd_reg[LEVEL_W-2:0], 1'b0};
            quot_reg <= {quot_reg[LEVEL_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

### rtl/core/trimmed_mean_moving_average_normalizer_top.sv
// Channel  | Direction | Handshake     | Payload
// burst    | in        | valid / ready | channel, sample_a .. sample_f
// result   | out       | valid / ready | out_channel, level
// APB      | in        | psel/penable  | full_scale_ch0 .. ch7 at 4*i
//
// One burst is in flight at a time; from acceptance to the result register a
// burst goes through trim with the history read, average and clamp, multiply,
// ten steps of the restoring divider, its done flag and the load of the result
// register. The next burst can be taken in the cycle after that load.
// A burst of an absent channel or a channel with zero full scale skips the divider.
// Reset clears the per-channel row valid flags, so history reads as zero at once.
// A stalled result waits in the output register while the next burst is worked on.
module trimmed_mean_moving_average_normalizer_top import tmman_pkg::*; #(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tmman_in_if.sink              burst,
    tmman_out_if.source           result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ROW_W = HIST_DEPTH * SAMPLE_BITS;
    localparam int SUM_W = SAMPLE_BITS + 3;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TRIM = 3'd1;
    localparam logic [2:0] S_AVG  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]             state_reg;
    logic [CHANNELS-1:0]    row_vld_reg;
    logic [CH_W-1:0]        ch_reg;
    logic [SAMPLE_BITS-1:0] samp_reg [NUM_SAMPLES];
    logic [SAMPLE_BITS-1:0] tm_reg;
    logic [FS_W-1:0]        clamp_reg;
    logic [FS_W-1:0]        fs_reg;
    logic [LEVEL_W-1:0]     level_reg;
    logic                   out_vld_reg;
    logic [CH_W-1:0]        out_ch_reg;
    logic [LEVEL_W-1:0]     out_level_reg;

    fs_array_t              full_scale;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    logic [IDX_W-1:0]       ch_idx;
    logic                   ch_present;
    logic [SAMPLE_BITS-1:0] burst_samp [NUM_SAMPLES];
    logic [SUM_W-1:0]       trim_sum;
    logic [SAMPLE_BITS-1:0] trim_hi;
    logic [SAMPLE_BITS-1:0] trim_lo;
    logic [SUM_W-1:0]       trim_mid;
    logic [ROW_W-1:0]       row_rd;
    logic [ROW_W-1:0]       row_hist;
    logic [ROW_W-1:0]       row_wr;
    logic                   row_we;
    logic [SAMPLE_BITS+1:0] avg_sum;
    logic [FS_W-1:0]        avg_fs;
    logic [FS_W-1:0]        fs_cur;
    logic                   load_out;

    tmman_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .full_scale (full_scale)
    );

    // Only the low SAMPLE_BITS bits of each sample take part.
    assign burst_samp[0] = SAMPLE_BITS'(burst.sample_a);
    assign burst_samp[1] = SAMPLE_BITS'(burst.sample_b);
    assign burst_samp[2] = SAMPLE_BITS'(burst.sample_c);
    assign burst_samp[3] = SAMPLE_BITS'(burst.sample_d);
    assign burst_samp[4] = SAMPLE_BITS'(burst.sample_e);
    assign burst_samp[5] = SAMPLE_BITS'(burst.sample_f);

    assign ch_present  = ({1'b0, burst.channel} < (CH_W+1)'(CHANNELS));
    assign ch_idx      = ch_reg[IDX_W-1:0];
    assign burst.ready = (state_reg == S_IDLE);

    always_comb
    begin
        trim_sum = '0;
        trim_hi  = samp_reg[0];
        trim_lo  = samp_reg[0];
        for (int k = 0; k < NUM_SAMPLES; k++)
        begin
            trim_sum = trim_sum + SUM_W'(samp_reg[k]);
            if (samp_reg[k] > trim_hi)
            begin
                trim_hi = samp_reg[k];
            end
            if (samp_reg[k] < trim_lo)
            begin
                trim_lo = samp_reg[k];
            end
        end
        trim_mid = trim_sum - SUM_W'(trim_hi) - SUM_W'(trim_lo);
    end

    tmman_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CHANNELS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (ch_idx),
        .wdata (row_wr),
        .raddr (ch_idx),
        .rdata (row_rd)
    );

    // A row never written since reset reads as all zero history.
    assign row_hist = row_vld_reg[ch_idx] ? row_rd : '0;
    assign row_we   = (state_reg == S_AVG);
    // Oldest entry sits in the low bits; drop it and append the new mean.
    assign row_wr   = {tm_reg, row_hist[ROW_W-1:SAMPLE_BITS]};

    assign avg_sum = (SAMPLE_BITS+2)'(tm_reg)
                   + (SAMPLE_BITS+2)'(row_hist[0*SAMPLE_BITS +: SAMPLE_BITS])
                   + (SAMPLE_BITS+2)'(row_hist[1*SAMPLE_BITS +: SAMPLE_BITS])
                   + (SAMPLE_BITS+2)'(row_hist[2*SAMPLE_BITS +: SAMPLE_BITS]);
    assign avg_fs  = FS_W'(avg_sum[SAMPLE_BITS+1:2]);
    assign fs_cur  = full_scale[ch_reg[FS_IDX_W-1:0]];

    assign div_req.start    = (state_reg == S_MUL) && (fs_reg != '0);
    assign div_req.dividend = PROD_W'(clamp_reg) * PROD_W'(LEVEL_SCALE);
    assign div_req.divisor  = fs_reg;

    tmman_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign load_out = (state_reg == S_DONE) && (!out_vld_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            row_vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (burst.valid)
                    begin
                        state_reg <= ch_present ? S_TRIM : S_DONE;
                    end
                end
                S_TRIM:
                begin
                    state_reg <= S_AVG;
                end
                S_AVG:
                begin
                    row_vld_reg[ch_idx] <= 1'b1;
                    state_reg           <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= (fs_reg == '0) ? S_DONE : S_DIV;
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst.valid && burst.ready)
        begin
            ch_reg    <= burst.channel;
            samp_reg  <= burst_samp;
            level_reg <= '0;
        end
        if (state_reg == S_TRIM)
        begin
            tm_reg <= trim_mid[SAMPLE_BITS+1:2];
        end
        if (state_reg == S_AVG)
        begin
            fs_reg    <= fs_cur;
            clamp_reg <= (avg_fs > fs_cur) ? fs_cur : avg_fs;
        end
        if ((state_reg == S_MUL) && (fs_reg == '0))
        begin
            level_reg <= '0;
        end
        if ((state_reg == S_DIV) && div_rsp.done)
        begin
            level_reg <= div_rsp.quotient;
        end
        if (load_out)
        begin
            out_ch_reg    <= ch_reg;
            out_level_reg <= level_reg;
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.out_channel = out_ch_reg;
    assign result.level       = out_level_reg;

endmodule

### tb/sv/trimmed_mean_moving_average_normalizer_top_test.sv
module trimmed_mean_moving_average_normalizer_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tmman_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned REG_STRIDE   = 4;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
    localparam int unsigned CH_MAX       = (1 << CH_W) - 1;
    localparam int unsigned FS_MAX       = (1 << FS_W) - 1;
    localparam int unsigned LEVEL_FULL   = 1000;
    localparam int unsigned RANDOM_PHASES     = 5;
    localparam int unsigned REQUESTS_PER_PHASE = 110;

    localparam logic [FS_W-1:0] FS_POWER_ON [FS_REGS] = '{
        14'd1590, 14'd1542, 14'd1680, 14'd1540,
        14'd1590, 14'd5030, 14'd5026, 14'd5690
    };

    typedef struct packed {
        logic [CH_W-1:0]                        channel;
        logic [NUM_SAMPLES-1:0][SAMPLE_W-1:0]   samples;
    } burst_t;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [LEVEL_W-1:0] level;
    } level_rec_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tmman_in_if  burst_if ();
    tmman_out_if result_if ();

    // Shadow of the block's registers and per-channel history.
    logic [FS_W-1:0]     full_scale_shadow [FS_REGS];
    logic [SAMPLE_W-1:0] trim_history [FS_REGS][HIST_DEPTH];

    level_rec_t  pending_levels [$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned hold_left = 0;
    bit          quiet_mode = 1'b0;

    trimmed_mean_moving_average_normalizer_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .burst   (burst_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("trimmed_mean_moving_average_normalizer_top_test: errors");
            $finish;
        end
    end

    function automatic level_rec_t predict_level(burst_t b);
        int unsigned total;
        int unsigned hi;
        int unsigned lo;
        int unsigned trimmed;
        int unsigned avg;
        int unsigned fs;
        int unsigned ch;
        level_rec_t  rec;
        ch = b.channel;
        hi = b.samples[0];
        lo = b.samples[0];
        total = 0;
        for (int k = 0; k < NUM_SAMPLES; k++)
        begin
            total += b.samples[k];
            if (b.samples[k] > hi)
                hi = b.samples[k];
            if (b.samples[k] < lo)
                lo = b.samples[k];
        end
        trimmed = (total - hi - lo) / 4;
        avg = trimmed;
        for (int k = 0; k < HIST_DEPTH; k++)
            avg += trim_history[ch][k];
        avg = avg / 4;
        for (int k = 0; k < HIST_DEPTH - 1; k++)
            trim_history[ch][k] = trim_history[ch][k + 1];
        trim_history[ch][HIST_DEPTH - 1] = SAMPLE_W'(trimmed);
        fs = full_scale_shadow[ch];
        if (avg > fs)
            avg = fs;
        rec.channel = b.channel;
        rec.level = (fs == 0) ? '0 : LEVEL_W'((LEVEL_FULL * avg) / fs);
        return rec;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic burst_t make_burst(int unsigned ch, int unsigned a, int unsigned b,
                                          int unsigned c, int unsigned d, int unsigned e,
                                          int unsigned f);
        burst_t br;
        br.channel = CH_W'(ch);
        br.samples[0] = SAMPLE_W'(a);
        br.samples[1] = SAMPLE_W'(b);
        br.samples[2] = SAMPLE_W'(c);
        br.samples[3] = SAMPLE_W'(d);
        br.samples[4] = SAMPLE_W'(e);
        br.samples[5] = SAMPLE_W'(f);
        return br;
    endfunction

    function automatic burst_t random_burst();
        burst_t      br;
        int unsigned style;
        int          base;
        int          v;
        br.channel = CH_W'($urandom_range(0, CH_MAX));
        style = $urandom_range(0, 9);
        base = $urandom_range(0, SAMPLE_MAX);
        for (int k = 0; k < NUM_SAMPLES; k++)
        begin
            if (style < 4)
                v = $urandom_range(0, SAMPLE_MAX);
            else if (style < 7)
            begin
                // Samples clustered around one level, like a steady sensor.
                v = base + $urandom_range(0, 64) - 32;
                if (v < 0)
                    v = 0;
                if (v > SAMPLE_MAX)
                    v = SAMPLE_MAX;
            end
            else if (style == 7)
                v = (k % 2 == 1) ? base : $urandom_range(0, SAMPLE_MAX);
            else if (style == 8)
                v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
            else
                v = $urandom_range(0, 15);
            br.samples[k] = SAMPLE_W'(v);
        end
        return br;
    endfunction

    function automatic logic [APB_DATA_W-1:0] random_full_scale_word();
        int unsigned r;
        int unsigned fs;
        r = $urandom_range(0, 99);
        if (r < 5)
            fs = 0;
        else if (r < 25)
            fs = $urandom_range(1, 64);
        else if (r < 35)
            fs = FS_MAX;
        else
            fs = $urandom_range(65, FS_MAX);
        // Bits above the register width must be dropped by the block.
        if ($urandom_range(0, 3) == 0)
            return ($urandom() & ~APB_DATA_W'(FS_MAX)) | APB_DATA_W'(fs);
        return APB_DATA_W'(fs);
    endfunction

    function automatic void note_mismatch(string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: mismatch: %s", $realtime, what);
    endfunction

    task automatic send_burst(burst_t b, int unsigned gap);
        @(negedge clk);
        if (gap > 0)
        begin
            burst_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_if.channel  = b.channel;
        burst_if.sample_a = b.samples[0];
        burst_if.sample_b = b.samples[1];
        burst_if.sample_c = b.samples[2];
        burst_if.sample_d = b.samples[3];
        burst_if.sample_e = b.samples[4];
        burst_if.sample_f = b.samples[5];
        burst_if.valid    = 1'b1;
        do
            @(posedge clk);
        while (!burst_if.ready);
        pending_levels.push_back(predict_level(b));
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic drain();
        @(negedge clk);
        burst_if.valid = 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_full_scale(int unsigned ch, logic [APB_DATA_W-1:0] wdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'(ch * REG_STRIDE);
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        full_scale_shadow[ch] = wdata[FS_W-1:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_burst(make_burst(0, 0, 0, 0, 0, 0, 0), pick_gap());
        send_burst(make_burst(1, 4095, 4095, 4095, 4095, 4095, 4095), pick_gap());
        send_burst(make_burst(2, 4095, 0, 4095, 0, 4095, 0), pick_gap());
        send_burst(make_burst(3, 'hAAA, 'h555, 'hAAA, 'h555, 'hAAA, 'h555), pick_gap());
        send_burst(make_burst(4, 1, 2, 3, 4, 5, 6), pick_gap());
        send_burst(make_burst(5, 4095, 4094, 4093, 4092, 4091, 4090), pick_gap());
        send_burst(make_burst(6, 100, 4095, 200, 0, 300, 400), pick_gap());
        send_burst(make_burst(7, 'h800, 'h800, 'h800, 'h800, 'h800, 'h800), pick_gap());
        // Repeated full-range bursts fill the history and push channel 0 into the clamp.
        repeat (4)
            send_burst(make_burst(0, 4095, 4095, 4095, 4095, 4095, 4095), pick_gap());
        drain();
    endtask

    task automatic test_full_scale_extremes();
        write_full_scale(0, 1);
        write_full_scale(1, FS_MAX);
        write_full_scale(2, 0);
        write_full_scale(3, 32'hFFFF_C000 | 32'd1000);
        write_full_scale(4, SAMPLE_MAX);
        write_full_scale(5, 2);
        send_burst(make_burst(0, 4095, 4095, 4095, 4095, 4095, 4095), pick_gap());
        send_burst(make_burst(0, 0, 0, 0, 0, 0, 0), pick_gap());
        send_burst(make_burst(1, 4095, 4095, 4095, 4095, 4095, 4095), pick_gap());
        send_burst(make_burst(2, 4095, 3000, 2000, 1000, 500, 0), pick_gap());
        send_burst(make_burst(3, 4000, 3990, 3980, 3970, 3960, 3950), pick_gap());
        // Four full-range bursts land exactly on a full scale of 4095.
        repeat (4)
            send_burst(make_burst(4, 4095, 4095, 4095, 4095, 4095, 4095), pick_gap());
        send_burst(make_burst(5, 7, 3, 9, 1, 5, 8), pick_gap());
        drain();
    endtask

    task automatic test_random_traffic();
        for (int unsigned p = 0; p < RANDOM_PHASES; p++)
        begin
            for (int unsigned ch = 0; ch < FS_REGS; ch++)
                write_full_scale(ch, random_full_scale_word());
            quiet_mode = (p == 2);
            repeat (REQUESTS_PER_PHASE)
                send_burst(random_burst(), pick_gap());
            drain();
            quiet_mode = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        for (int unsigned ch = 0; ch < FS_REGS; ch++)
            write_full_scale(ch, FS_POWER_ON[ch]);
        @(posedge clk);
        hold_left = LONG_HOLD;
        repeat (24)
            send_burst(random_burst(), 0);
        drain();
    endtask

    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_if.ready = 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                result_if.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                result_if.ready = 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_result
        level_rec_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_levels.size() == 0)
                note_mismatch($sformatf("result ch %0d level %0d with no request outstanding",
                                        result_if.out_channel, result_if.level));
            else
            begin
                want = pending_levels.pop_front();
                if (result_if.out_channel !== want.channel)
                    note_mismatch($sformatf("out_channel expected %0d got %0d",
                                            want.channel, result_if.out_channel));
                if (result_if.level !== want.level)
                    note_mismatch($sformatf("level on ch %0d expected %0d got %0d",
                                            want.channel, want.level, result_if.level));
            end
        end
    end

    initial
    begin
        burst_if.valid    = 1'b0;
        burst_if.channel  = '0;
        burst_if.sample_a = '0;
        burst_if.sample_b = '0;
        burst_if.sample_c = '0;
        burst_if.sample_d = '0;
        burst_if.sample_e = '0;
        burst_if.sample_f = '0;
        result_if.ready   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        for (int ch = 0; ch < FS_REGS; ch++)
        begin
            full_scale_shadow[ch] = FS_POWER_ON[ch];
            for (int k = 0; k < HIST_DEPTH; k++)
                trim_history[ch][k] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_full_scale_extremes();
        test_random_traffic();
        test_backpressure();

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_levels.size() == 0)
            $display("trimmed_mean_moving_average_normalizer_top_test: clean");
        else
            $display("trimmed_mean_moving_average_normalizer_top_test: errors");
        $finish;
    end

endmodule
